@@ design/mmmc_pkg.sv @@
`default_nettype none
package mmmc_pkg;

  // fixed sizes of the region table and coordinates
  localparam int MAX_REGIONS = 16;
  localparam int COORD_BITS  = 24;
  localparam int SLOT_BITS   = $clog2(MAX_REGIONS);
  localparam int CNT_BITS    = 5;
  localparam int THR_BITS    = 16;
  localparam int MODE_BITS   = 4;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  // event opcodes
  localparam logic [2:0] OP_RESULT   = 3'd0;
  localparam logic [2:0] OP_LOCATION = 3'd1;
  localparam logic [2:0] OP_START    = 3'd2;
  localparam logic [2:0] OP_PAUSE    = 3'd3;
  localparam logic [2:0] OP_GOHOME   = 3'd4;
  localparam logic [2:0] OP_RESET    = 3'd5;
  localparam logic [2:0] OP_MAP      = 3'd6;
  localparam logic [2:0] OP_LOAD_RS  = 3'd7;

  // behaviour result codes
  localparam logic [1:0] RES_RUNNING  = 2'd0;
  localparam logic [1:0] RES_FINISHED = 2'd1;
  localparam logic [1:0] RES_OBSTACLE = 2'd2;

  // fix quality codes
  localparam logic [1:0] FIX_NONE  = 2'd0;
  localparam logic [1:0] FIX_FIXED = 2'd1;
  localparam logic [1:0] FIX_FLOAT = 2'd2;

  // mission mode codes, as reported on the result word
  localparam logic [3:0] MODE_IDLE     = 4'd0;
  localparam logic [3:0] MODE_LOCATE   = 4'd1;
  localparam logic [3:0] MODE_TRANSFER = 4'd2;
  localparam logic [3:0] MODE_WORK     = 4'd3;
  localparam logic [3:0] MODE_STRUGGLE = 4'd4;
  localparam logic [3:0] MODE_GOHOME   = 4'd5;
  localparam logic [3:0] MODE_DOCK     = 4'd6;
  localparam logic [3:0] MODE_PAUSED   = 4'd7;
  localparam logic [3:0] MODE_STUCK    = 4'd8;
  localparam logic [3:0] MODE_FAULT    = 4'd9;

  // notice codes
  localparam logic [1:0] NOTE_NONE    = 2'd0;
  localparam logic [1:0] NOTE_STARTED = 2'd1;
  localparam logic [1:0] NOTE_PAUSED  = 2'd2;
  localparam logic [1:0] NOTE_RESUMED = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_REGION_COUNT = 3'd0;
  localparam logic [2:0] CFG_HOME_X       = 3'd1;
  localparam logic [2:0] CFG_HOME_Y       = 3'd2;
  localparam logic [2:0] CFG_NEAR_HOME    = 3'd3;
  localparam logic [2:0] CFG_ARRIVED      = 3'd4;

  // reset values of the configuration registers
  localparam logic [CNT_BITS-1:0] RST_REGION_COUNT = 5'd1;
  localparam logic [THR_BITS-1:0] RST_NEAR_HOME    = 16'd500;
  localparam logic [THR_BITS-1:0] RST_ARRIVED      = 16'd300;

  // one input event
  typedef struct packed {
    logic [2:0]                   opcode;
    logic [1:0]                   behaviour_result;
    logic [1:0]                   fix_quality;
    logic                         heading_ok;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [SLOT_BITS-1:0]         region_slot;
  } event_t;

  // one result word
  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [SLOT_BITS-1:0] region;
    logic [1:0]           notice;
    logic                 load_path;
    logic                 gnss_fixed;
    logic                 map_ready;
  } result_t;

endpackage
`default_nettype wire

@@ design/mowing_mission_mode_controller_unit.sv @@
// throughput: one event word per cycle when the result side does not stall; the whole
//   mode update, including the table read and the squared-distance compare, is done
//   between the input and result registers
// reset (synchronous, rst_n low): idle mode, region 0, no map, no fix, position zero,
//   configuration back to defaults; the region start table is not cleared
`default_nettype none
module mowing_mission_mode_controller_unit
  import mmmc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // tdata: behaviour_result[1:0], fix_quality[3:2], heading_ok[4], pos_x[28:5],
  //        pos_y[52:29], region_slot[56:53], zero fill[63:57]
  input  wire logic [63:0]              in_tdata,
  // tuser: opcode[2:0]
  input  wire logic [2:0]               in_tuser,
  // result channel
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // tdata: mode[3:0], region[7:4], notice[9:8], load_path[10], gnss_fixed[11],
  //        map_ready[12], zero fill[15:13]
  output logic [15:0]                   out_tdata,
  // configuration port
  input  wire logic                     cfg_we,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  // configuration registers
  logic [CNT_BITS-1:0]          region_count_r;
  logic signed [COORD_BITS-1:0] home_x_r;
  logic signed [COORD_BITS-1:0] home_y_r;
  logic [2*THR_BITS-1:0]        near_sq_r;
  logic [2*THR_BITS-1:0]        arrived_sq_r;

  // mission state
  logic [MODE_BITS-1:0]         cur_mode_r, cur_mode_nxt;
  logic [MODE_BITS-1:0]         mbp_r, mbp_nxt;
  logic [MODE_BITS-1:0]         mbl_r, mbl_nxt;
  logic [SLOT_BITS-1:0]         region_r, region_nxt;
  logic                         map_loaded_r, map_loaded_nxt;
  logic [1:0]                   fix_code_r, fix_code_nxt;
  logic signed [COORD_BITS-1:0] robot_x_r, robot_x_nxt;
  logic signed [COORD_BITS-1:0] robot_y_r, robot_y_nxt;

  // region start table
  logic signed [COORD_BITS-1:0] rs_x_r [MAX_REGIONS];
  logic signed [COORD_BITS-1:0] rs_y_r [MAX_REGIONS];

  // input and result registers
  logic    in_valid_r;
  event_t  ev_r;
  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    advance;

  // handshake: the input register moves on whenever the result register is free
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.map_ready, res_r.gnss_fixed, res_r.load_path,
                       res_r.notice, res_r.region, res_r.mode};

  // threshold written by the configuration port, squared
  logic [2*THR_BITS-1:0] cfg_thr;
  logic [2*THR_BITS-1:0] cfg_thr_sq;

  assign cfg_thr    = (2*THR_BITS)'(cfg_wdata[THR_BITS-1:0]);
  assign cfg_thr_sq = cfg_thr * cfg_thr;

  // configuration writes, thresholds kept squared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= RST_REGION_COUNT;
      home_x_r       <= '0;
      home_y_r       <= '0;
      near_sq_r      <= (2*THR_BITS)'(RST_NEAR_HOME) * (2*THR_BITS)'(RST_NEAR_HOME);
      arrived_sq_r   <= (2*THR_BITS)'(RST_ARRIVED) * (2*THR_BITS)'(RST_ARRIVED);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_REGION_COUNT: region_count_r <= cfg_wdata[CNT_BITS-1:0];
        CFG_HOME_X:       home_x_r       <= cfg_wdata[COORD_BITS-1:0];
        CFG_HOME_Y:       home_y_r       <= cfg_wdata[COORD_BITS-1:0];
        CFG_NEAR_HOME:    near_sq_r      <= cfg_thr_sq;
        CFG_ARRIVED:      arrived_sq_r   <= cfg_thr_sq;
        default: ;
      endcase
    end
  end

  // distance check: one shared compare, target picked by the event
  logic                         last_region;
  logic [CNT_BITS-1:0]          eff_count;
  logic                         use_home;
  logic [SLOT_BITS-1:0]         idx_sel;
  logic signed [COORD_BITS-1:0] px_sel, py_sel, tx_sel, ty_sel;
  logic signed [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS:0]          adx, ady;
  logic [2*THR_BITS-1:0]        sq_x, sq_y, thr_sq;
  logic [2*THR_BITS:0]          sq_sum;
  logic                         hit;

  always_comb begin
    if (region_count_r == '0) begin
      eff_count = CNT_BITS'(1);
    end else if (region_count_r > CNT_BITS'(MAX_REGIONS)) begin
      eff_count = CNT_BITS'(MAX_REGIONS);
    end else begin
      eff_count = region_count_r;
    end
    last_region = ({1'b0, region_r} + CNT_BITS'(1)) >= eff_count;
  end

  always_comb begin
    unique case (ev_r.opcode)
      OP_RESULT:   use_home = last_region;
      OP_LOCATION: use_home = (mbl_r == MODE_GOHOME);
      OP_GOHOME:   use_home = 1'b1;
      default:     use_home = 1'b0;
    endcase
    idx_sel = (ev_r.opcode == OP_RESULT) ? region_r + SLOT_BITS'(1) : region_r;
    px_sel  = (ev_r.opcode == OP_LOCATION) ? ev_r.pos_x : robot_x_r;
    py_sel  = (ev_r.opcode == OP_LOCATION) ? ev_r.pos_y : robot_y_r;
    tx_sel  = use_home ? home_x_r : rs_x_r[idx_sel];
    ty_sel  = use_home ? home_y_r : rs_y_r[idx_sel];
    thr_sq  = use_home ? near_sq_r : arrived_sq_r;
    dx      = {px_sel[COORD_BITS-1], px_sel} - {tx_sel[COORD_BITS-1], tx_sel};
    dy      = {py_sel[COORD_BITS-1], py_sel} - {ty_sel[COORD_BITS-1], ty_sel};
    adx     = dx[COORD_BITS] ? (COORD_BITS+1)'(0) - dx : dx;
    ady     = dy[COORD_BITS] ? (COORD_BITS+1)'(0) - dy : dy;
    sq_x    = (2*THR_BITS)'(adx[THR_BITS-1:0]) * (2*THR_BITS)'(adx[THR_BITS-1:0]);
    sq_y    = (2*THR_BITS)'(ady[THR_BITS-1:0]) * (2*THR_BITS)'(ady[THR_BITS-1:0]);
    sq_sum  = {1'b0, sq_x} + {1'b0, sq_y};
    hit     = (adx[COORD_BITS:THR_BITS] == '0) && (ady[COORD_BITS:THR_BITS] == '0)
              && (sq_sum < {1'b0, thr_sq});
  end

  // mode update for the event in the input register
  logic                 do_enter;
  logic [MODE_BITS-1:0] enter_mode;
  logic [MODE_BITS-1:0] final_mode;
  logic                 final_ok;
  logic [1:0]           notice;
  logic                 load_path;
  logic                 good_fix;

  always_comb begin
    cur_mode_nxt   = cur_mode_r;
    mbp_nxt        = mbp_r;
    mbl_nxt        = mbl_r;
    region_nxt     = region_r;
    map_loaded_nxt = map_loaded_r;
    fix_code_nxt   = fix_code_r;
    robot_x_nxt    = robot_x_r;
    robot_y_nxt    = robot_y_r;
    do_enter       = 1'b0;
    enter_mode     = MODE_IDLE;
    notice         = NOTE_NONE;
    load_path      = 1'b0;
    good_fix       = (ev_r.fix_quality == FIX_FIXED || ev_r.fix_quality == FIX_FLOAT)
                     && ev_r.heading_ok;

    unique case (ev_r.opcode)
      OP_RESULT: begin
        if (cur_mode_r != MODE_PAUSED) begin
          if (ev_r.behaviour_result == RES_OBSTACLE) begin
            do_enter   = 1'b1;
            enter_mode = MODE_STRUGGLE;
          end else if (ev_r.behaviour_result == RES_FINISHED) begin
            unique case (cur_mode_r)
              MODE_DOCK: begin
                do_enter   = 1'b1;
                enter_mode = MODE_IDLE;
              end
              MODE_GOHOME: begin
                do_enter   = 1'b1;
                enter_mode = MODE_DOCK;
              end
              MODE_TRANSFER, MODE_STRUGGLE: begin
                do_enter   = 1'b1;
                enter_mode = MODE_WORK;
              end
              MODE_WORK: begin
                do_enter = 1'b1;
                if (last_region) begin
                  region_nxt = '0;
                  enter_mode = MODE_GOHOME;
                end else begin
                  region_nxt = region_r + SLOT_BITS'(1);
                  enter_mode = MODE_TRANSFER;
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_LOCATION: begin
        fix_code_nxt = ev_r.fix_quality;
        robot_x_nxt  = ev_r.pos_x;
        robot_y_nxt  = ev_r.pos_y;
        if (good_fix) begin
          if (cur_mode_r == MODE_LOCATE) begin
            do_enter   = 1'b1;
            enter_mode = mbl_r;
          end
        end else if (cur_mode_r == MODE_GOHOME || cur_mode_r == MODE_TRANSFER ||
                     cur_mode_r == MODE_WORK   || cur_mode_r == MODE_STRUGGLE) begin
          mbl_nxt    = cur_mode_r;
          do_enter   = 1'b1;
          enter_mode = MODE_LOCATE;
        end
      end
      OP_START: begin
        if (map_loaded_r) begin
          if (cur_mode_r == MODE_PAUSED) begin
            cur_mode_nxt = mbp_r;
            notice       = NOTE_RESUMED;
          end else if (cur_mode_r == MODE_IDLE) begin
            do_enter = 1'b1;
            if (fix_code_r == FIX_FIXED || fix_code_r == FIX_FLOAT) begin
              enter_mode = MODE_TRANSFER;
            end else begin
              mbl_nxt    = MODE_TRANSFER;
              enter_mode = MODE_LOCATE;
            end
          end
        end
      end
      OP_PAUSE: begin
        if (cur_mode_r == MODE_DOCK || cur_mode_r == MODE_GOHOME ||
            cur_mode_r == MODE_TRANSFER || cur_mode_r == MODE_WORK ||
            cur_mode_r == MODE_STRUGGLE) begin
          mbp_nxt      = cur_mode_r;
          cur_mode_nxt = MODE_PAUSED;
          notice       = NOTE_PAUSED;
        end
      end
      OP_GOHOME: begin
        if (map_loaded_r) begin
          if (cur_mode_r == MODE_WORK || cur_mode_r == MODE_TRANSFER ||
              cur_mode_r == MODE_STRUGGLE || cur_mode_r == MODE_IDLE) begin
            do_enter   = 1'b1;
            enter_mode = MODE_GOHOME;
          end else if (cur_mode_r == MODE_PAUSED) begin
            if (mbp_r == MODE_GOHOME) begin
              cur_mode_nxt = mbp_r;
              notice       = NOTE_RESUMED;
            end else if (mbp_r == MODE_TRANSFER || mbp_r == MODE_WORK ||
                         mbp_r == MODE_STRUGGLE) begin
              do_enter   = 1'b1;
              enter_mode = MODE_GOHOME;
            end
          end
        end
      end
      OP_RESET: begin
        do_enter   = 1'b1;
        enter_mode = MODE_IDLE;
        region_nxt = '0;
      end
      OP_MAP: begin
        do_enter       = 1'b1;
        enter_mode     = MODE_IDLE;
        map_loaded_nxt = 1'b1;
      end
      OP_LOAD_RS: ;
      default: ;
    endcase

    // mode entry: arrival goes on to working, near home goes on to docking
    final_ok   = 1'b1;
    final_mode = enter_mode;
    unique case (enter_mode)
      MODE_TRANSFER: final_mode = hit ? MODE_WORK : MODE_TRANSFER;
      MODE_GOHOME:   final_mode = hit ? MODE_DOCK : MODE_GOHOME;
      MODE_IDLE, MODE_LOCATE, MODE_WORK, MODE_STRUGGLE, MODE_DOCK,
      MODE_STUCK, MODE_FAULT: ;
      default:       final_ok = 1'b0;
    endcase
    if (do_enter && final_ok) begin
      cur_mode_nxt = final_mode;
      notice       = NOTE_STARTED;
      load_path    = (final_mode == MODE_WORK) && (cur_mode_r == MODE_TRANSFER);
    end

    res_nxt.mode       = cur_mode_nxt;
    res_nxt.region     = region_nxt;
    res_nxt.notice     = notice;
    res_nxt.load_path  = load_path;
    res_nxt.gnss_fixed = (fix_code_nxt == FIX_FIXED || fix_code_nxt == FIX_FLOAT);
    res_nxt.map_ready  = map_loaded_nxt;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ev_r.opcode           <= in_tuser;
      ev_r.behaviour_result <= in_tdata[1:0];
      ev_r.fix_quality      <= in_tdata[3:2];
      ev_r.heading_ok       <= in_tdata[4];
      ev_r.pos_x            <= in_tdata[28:5];
      ev_r.pos_y            <= in_tdata[52:29];
      ev_r.region_slot      <= in_tdata[56:53];
    end
  end

  // mission state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mode_r   <= MODE_IDLE;
      mbp_r        <= MODE_IDLE;
      mbl_r        <= MODE_IDLE;
      region_r     <= '0;
      map_loaded_r <= 1'b0;
      fix_code_r   <= FIX_NONE;
      robot_x_r    <= '0;
      robot_y_r    <= '0;
    end else if (advance) begin
      cur_mode_r   <= cur_mode_nxt;
      mbp_r        <= mbp_nxt;
      mbl_r        <= mbl_nxt;
      region_r     <= region_nxt;
      map_loaded_r <= map_loaded_nxt;
      fix_code_r   <= fix_code_nxt;
      robot_x_r    <= robot_x_nxt;
      robot_y_r    <= robot_y_nxt;
    end
  end

  // region start table write
  always_ff @(posedge clk) begin
    if (advance && ev_r.opcode == OP_LOAD_RS) begin
      rs_x_r[ev_r.region_slot] <= ev_r.pos_x;
      rs_y_r[ev_r.region_slot] <= ev_r.pos_y;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
  import mmmc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_PHASES = 7;
  localparam int WORDS_PER_PHASE = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  mowing_mission_mode_controller_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // tdata: behaviour_result, fix_quality, heading_ok, pos_x, pos_y, region_slot, zero fill
    .in_tdata   (in_tdata),
    // tuser: opcode
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // tdata: mode, region, notice, load_path, gnss_fixed, map_ready, zero fill
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // shadow of the configuration registers
  logic [4:0]         c_count = RST_REGION_COUNT;
  logic signed [23:0] c_home_x = '0;
  logic signed [23:0] c_home_y = '0;
  logic [15:0]        c_near = RST_NEAR_HOME;
  logic [15:0]        c_arrived = RST_ARRIVED;

  // shadow of the mission state
  logic [3:0]         pm_mode = MODE_IDLE;
  logic [3:0]         pm_pause_mode = MODE_IDLE;
  logic [3:0]         pm_locate_mode = MODE_IDLE;
  logic [3:0]         pm_region = '0;
  logic               pm_map = 1'b0;
  logic [1:0]         pm_fix = FIX_NONE;
  logic signed [23:0] pm_x = '0;
  logic signed [23:0] pm_y = '0;
  logic signed [23:0] start_x [MAX_REGIONS];
  logic signed [23:0] start_y [MAX_REGIONS];
  logic [1:0]         step_note;
  logic               step_load;

  result_t pending_reports [$];
  int      events_sent = 0;
  int      reports_checked = 0;
  int      mismatches = 0;
  int      path_loads = 0;
  logic [15:0] modes_seen = '0;
  bit      calm = 1'b0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still due", CYCLE_LIMIT,
             pending_reports.size());
    $display("FAIL");
    $finish;
  end

  // gap length for either side: mostly short, a few long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [23:0] offset_near(int unsigned span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - int'(span);
    return d[23:0];
  endfunction

  // exact squared distance test, with the far-axis cutoff
  function automatic bit is_close(logic signed [23:0] ax, logic signed [23:0] ay,
                                  logic signed [23:0] bx, logic signed [23:0] by,
                                  logic [15:0] thr);
    longint dx, dy;
    longint unsigned adx, ady, lim;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    lim = 64'(thr);
    if (adx > 65535 || ady > 65535) return 1'b0;
    return (adx * adx + ady * ady) < (lim * lim);
  endfunction

  function automatic int region_total();
    if (c_count == 0) return 1;
    if (c_count > MAX_REGIONS) return MAX_REGIONS;
    return int'(c_count);
  endfunction

  // mode entry, following through arrival and near-home shortcuts
  task automatic switch_mode(input logic [3:0] target);
    logic [3:0] m;
    m = target;
    if (m == MODE_PAUSED || m > MODE_FAULT) return;
    if (m == MODE_TRANSFER &&
        is_close(pm_x, pm_y, start_x[pm_region], start_y[pm_region], c_arrived))
      m = MODE_WORK;
    else if (m == MODE_GOHOME && is_close(pm_x, pm_y, c_home_x, c_home_y, c_near))
      m = MODE_DOCK;
    if (m == MODE_WORK && pm_mode == MODE_TRANSFER) step_load = 1'b1;
    pm_mode = m;
    step_note = NOTE_STARTED;
  endtask

  task automatic resume_mission();
    pm_mode = pm_pause_mode;
    step_note = NOTE_RESUMED;
  endtask

  // next mission state and report for one event word
  task automatic mission_step(input event_t ev, output result_t rep);
    logic fix_good;
    step_note = NOTE_NONE;
    step_load = 1'b0;
    case (ev.opcode)
      OP_RESULT: begin
        if (pm_mode != MODE_PAUSED) begin
          if (ev.behaviour_result == RES_OBSTACLE) begin
            switch_mode(MODE_STRUGGLE);
          end else if (ev.behaviour_result == RES_FINISHED) begin
            case (pm_mode)
              MODE_DOCK:     switch_mode(MODE_IDLE);
              MODE_GOHOME:   switch_mode(MODE_DOCK);
              MODE_TRANSFER: switch_mode(MODE_WORK);
              MODE_STRUGGLE: switch_mode(MODE_WORK);
              MODE_WORK: begin
                if (int'(pm_region) + 1 >= region_total()) begin
                  pm_region = '0;
                  switch_mode(MODE_GOHOME);
                end else begin
                  pm_region = pm_region + 1'b1;
                  switch_mode(MODE_TRANSFER);
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_LOCATION: begin
        pm_fix = ev.fix_quality;
        pm_x = ev.pos_x;
        pm_y = ev.pos_y;
        fix_good = (ev.fix_quality == FIX_FIXED || ev.fix_quality == FIX_FLOAT);
        if (fix_good && ev.heading_ok) begin
          if (pm_mode == MODE_LOCATE) switch_mode(pm_locate_mode);
        end else if (pm_mode == MODE_GOHOME || pm_mode == MODE_TRANSFER ||
                     pm_mode == MODE_WORK || pm_mode == MODE_STRUGGLE) begin
          pm_locate_mode = pm_mode;
          switch_mode(MODE_LOCATE);
        end
      end
      OP_START: begin
        if (pm_map) begin
          if (pm_mode == MODE_PAUSED) begin
            resume_mission();
          end else if (pm_mode == MODE_IDLE) begin
            if (pm_fix == FIX_FIXED || pm_fix == FIX_FLOAT) begin
              switch_mode(MODE_TRANSFER);
            end else begin
              pm_locate_mode = MODE_TRANSFER;
              switch_mode(MODE_LOCATE);
            end
          end
        end
      end
      OP_PAUSE: begin
        if (pm_mode == MODE_DOCK || pm_mode == MODE_GOHOME || pm_mode == MODE_TRANSFER ||
            pm_mode == MODE_WORK || pm_mode == MODE_STRUGGLE) begin
          pm_pause_mode = pm_mode;
          pm_mode = MODE_PAUSED;
          step_note = NOTE_PAUSED;
        end
      end
      OP_GOHOME: begin
        if (pm_map) begin
          if (pm_mode == MODE_WORK || pm_mode == MODE_TRANSFER ||
              pm_mode == MODE_STRUGGLE || pm_mode == MODE_IDLE) begin
            switch_mode(MODE_GOHOME);
          end else if (pm_mode == MODE_PAUSED) begin
            if (pm_pause_mode == MODE_GOHOME)
              resume_mission();
            else if (pm_pause_mode == MODE_TRANSFER || pm_pause_mode == MODE_WORK ||
                     pm_pause_mode == MODE_STRUGGLE)
              switch_mode(MODE_GOHOME);
          end
        end
      end
      OP_RESET: begin
        switch_mode(MODE_IDLE);
        pm_region = '0;
      end
      OP_MAP: begin
        switch_mode(MODE_IDLE);
        pm_map = 1'b1;
      end
      default: begin
        start_x[ev.region_slot] = ev.pos_x;
        start_y[ev.region_slot] = ev.pos_y;
      end
    endcase
    rep.mode = pm_mode;
    rep.region = pm_region;
    rep.notice = step_note;
    rep.load_path = step_load;
    rep.gnss_fixed = (pm_fix == FIX_FIXED || pm_fix == FIX_FLOAT);
    rep.map_ready = pm_map;
    modes_seen[pm_mode] = 1'b1;
    if (step_load) path_loads++;
  endtask

  function automatic event_t mk_event(logic [2:0] op, logic [1:0] res, logic [1:0] fq,
                                      logic hd, logic signed [23:0] x,
                                      logic signed [23:0] y, logic [3:0] slot);
    event_t ev;
    ev.opcode = op;
    ev.behaviour_result = res;
    ev.fix_quality = fq;
    ev.heading_ok = hd;
    ev.pos_x = x;
    ev.pos_y = y;
    ev.region_slot = slot;
    return ev;
  endfunction

  // send one event word and record the report it should cause
  task automatic send_event(input event_t ev);
    int      gap;
    result_t want;
    gap = pick_pause();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ev.opcode;
    in_tdata  <= {7'b0, ev.region_slot, ev.pos_y, ev.pos_x, ev.heading_ok,
                  ev.fix_quality, ev.behaviour_result};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mission_step(ev, want);
    pending_reports.push_back(want);
    events_sent++;
  endtask

  // stop sending and let every due report come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write all registers while the block is idle; junk above the count and threshold widths
  task automatic set_config(input logic [4:0] cnt, input logic signed [23:0] hx,
                            input logic signed [23:0] hy, input logic [15:0] nh,
                            input logic [15:0] ar);
    logic [23:0] junk;
    junk = 24'($urandom);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_REGION_COUNT;
    cfg_wdata <= {junk[23:5], cnt};
    @(posedge clk);
    cfg_addr <= CFG_HOME_X;
    cfg_wdata <= hx;
    @(posedge clk);
    cfg_addr <= CFG_HOME_Y;
    cfg_wdata <= hy;
    @(posedge clk);
    cfg_addr <= CFG_NEAR_HOME;
    cfg_wdata <= {junk[7:0], nh};
    @(posedge clk);
    cfg_addr <= CFG_ARRIVED;
    cfg_wdata <= {junk[15:8], ar};
    @(posedge clk);
    cfg_we <= 1'b0;
    c_count = cnt;
    c_home_x = hx;
    c_home_y = hy;
    c_near = nh;
    c_arrived = ar;
  endtask

  // result side: random stalls and in-order compare
  always @(posedge clk) begin : check_results
    result_t got, want;
    int      hold;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[3:0], out_tdata[7:4], out_tdata[9:8], out_tdata[10],
             out_tdata[11], out_tdata[12]};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word %h", $time, out_tdata);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (got.mode != want.mode || got.region != want.region ||
            got.notice != want.notice || got.load_path != want.load_path ||
            got.gnss_fixed != want.gnss_fixed || got.map_ready != want.map_ready) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: report %0d mismatch", $time, reports_checked);
            $display("  expected mode %0d region %0d notice %0d load %0b fix %0b map %0b",
                     want.mode, want.region, want.notice, want.load_path,
                     want.gnss_fixed, want.map_ready);
            $display("  got      mode %0d region %0d notice %0d load %0b fix %0b map %0b",
                     got.mode, got.region, got.notice, got.load_path,
                     got.gnss_fixed, got.map_ready);
          end
        end
      end
    end
    if (hold > 0) begin
      hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      hold = pick_pause();
    end
  end

  // every slot gets a start point before any transfer can read it
  task automatic test_region_table();
    int i;
    send_event(mk_event(OP_LOAD_RS, 2'd0, 2'd0, 1'b0, 24'sd1000, 24'sd2000, 4'd0));
    send_event(mk_event(OP_LOAD_RS, 2'd3, 2'd3, 1'b1, 24'h7FFFFF, 24'h800000, 4'd1));
    send_event(mk_event(OP_LOAD_RS, 2'd0, 2'd0, 1'b0, 24'h800000, 24'h7FFFFF, 4'd15));
    for (i = 2; i < MAX_REGIONS - 1; i++)
      send_event(mk_event(OP_LOAD_RS, 2'd0, 2'd0, 1'b0, offset_near(30000),
                          offset_near(30000), i[3:0]));
  endtask

  // walk through every command but the table load, and the corner cases, with default settings
  task automatic test_directed_modes();
    send_event(mk_event(OP_START, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_GOHOME, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_RESULT, 2'd3, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_RESULT, RES_OBSTACLE, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_RESET, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_MAP, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_LOCATION, 2'd0, FIX_NONE, 1'b0, 24'sd0, 24'sd0, 4'd0));
    // start without a fix goes to locating first
    send_event(mk_event(OP_START, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_RESULT, RES_FINISHED, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    // fix arrives at the region start: transfer falls through to working
    send_event(mk_event(OP_LOCATION, 2'd0, FIX_FLOAT, 1'b1, 24'sd1100, 24'sd2050, 4'd0));
    send_event(mk_event(OP_RESULT, RES_FINISHED, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    // pause on the way home, ignored result, resume by go-home
    send_event(mk_event(OP_PAUSE, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_RESULT, RES_OBSTACLE, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_GOHOME, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    // fix lost, then regained near home: going home falls through to docking
    send_event(mk_event(OP_LOCATION, 2'd0, 2'd3, 1'b1, 24'sd5000, 24'sd5000, 4'd0));
    send_event(mk_event(OP_LOCATION, 2'd0, FIX_FIXED, 1'b1, 24'sd100, -24'sd100, 4'd0));
    send_event(mk_event(OP_RESULT, RES_FINISHED, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    // transfer then working with a path load
    send_event(mk_event(OP_START, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_RESULT, RES_FINISHED, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_PAUSE, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_START, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    // heading not set counts as lost fix
    send_event(mk_event(OP_LOCATION, 2'd0, FIX_FIXED, 1'b0, 24'sd100, -24'sd100, 4'd0));
    send_event(mk_event(OP_GOHOME, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_RESET, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    drain();
  endtask

  // widest thresholds: an axis offset of 65536 never counts as near
  task automatic test_large_offsets();
    set_config(5'd2, 24'sd0, 24'sd0, 16'hFFFF, 16'hFFFF);
    send_event(mk_event(OP_LOAD_RS, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_LOAD_RS, 2'd0, 2'd0, 1'b0, 24'sd105535, -24'sd40000, 4'd1));
    send_event(mk_event(OP_LOCATION, 2'd0, FIX_FIXED, 1'b1, 24'sd65536, 24'sd0, 4'd0));
    send_event(mk_event(OP_START, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_RESET, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_LOCATION, 2'd0, FIX_FIXED, 1'b1, 24'sd40000, -24'sd40000, 4'd0));
    send_event(mk_event(OP_START, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_RESULT, RES_FINISHED, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    send_event(mk_event(OP_GOHOME, 2'd0, 2'd0, 1'b0, 24'sd0, 24'sd0, 4'd0));
    drain();
  endtask

  // mostly mission-shaped events steered by the current state, some noise
  task automatic gen_mission_event(output event_t ev);
    int pick, r;
    ev.opcode = OP_RESULT;
    ev.behaviour_result = 2'($urandom_range(0, 3));
    ev.fix_quality = 2'($urandom_range(0, 3));
    ev.heading_ok = 1'($urandom_range(0, 1));
    ev.pos_x = 24'($urandom);
    ev.pos_y = 24'($urandom);
    ev.region_slot = SLOT_BITS'($urandom_range(0, MAX_REGIONS - 1));
    pick = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    if (pick < 40) begin
      ev.opcode = OP_RESULT;
      if (r < 70) ev.behaviour_result = RES_FINISHED;
      else if (r < 85) ev.behaviour_result = RES_OBSTACLE;
    end else if (pick < 60) begin
      ev.opcode = OP_LOCATION;
      if (r < 75) begin
        ev.fix_quality = 2'($urandom_range(FIX_FIXED, FIX_FLOAT));
        ev.heading_ok = 1'b1;
      end
      r = $urandom_range(0, 9);
      if (r < 4) begin
        ev.pos_x = start_x[pm_region] + offset_near(c_arrived + 16);
        ev.pos_y = start_y[pm_region] + offset_near(c_arrived + 16);
      end else if (r < 7) begin
        ev.pos_x = c_home_x + offset_near(c_near + 16);
        ev.pos_y = c_home_y + offset_near(c_near + 16);
      end else if (r < 8) begin
        ev.pos_x = start_x[pm_region] + offset_near(70000);
        ev.pos_y = start_y[pm_region] + offset_near(70000);
      end
    end else if (pick < 70) begin
      ev.opcode = OP_START;
    end else if (pick < 77) begin
      ev.opcode = OP_PAUSE;
    end else if (pick < 83) begin
      ev.opcode = OP_GOHOME;
    end else if (pick < 86) begin
      ev.opcode = OP_RESET;
    end else if (pick < 89) begin
      ev.opcode = OP_MAP;
    end else begin
      ev.opcode = OP_LOAD_RS;
      if (r < 50) begin
        ev.pos_x = pm_x + offset_near(c_arrived + 16);
        ev.pos_y = pm_y + offset_near(c_arrived + 16);
      end
    end
  endtask

  // random missions over several register settings, extremes included
  task automatic test_random_missions();
    int     ph, i;
    event_t ev;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: set_config(5'd3, 24'sd0, 24'sd0, 16'd500, 16'd300);
        1: set_config(5'd0, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
        2: set_config(5'd31, 24'h800000, 24'h800000, 16'd0, 16'd0);
        3: set_config(5'd16, 24'($urandom), 24'($urandom), 16'd2000, 16'd1500);
        4: set_config(5'd1, offset_near(5000), offset_near(5000), 16'd800, 16'd400);
        default: set_config(5'($urandom_range(0, 31)), offset_near(20000),
                            offset_near(20000), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)));
      endcase
      for (i = 0; i < WORDS_PER_PHASE; i++) begin
        if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
        gen_mission_event(ev);
        send_event(ev);
      end
      calm = 1'b0;
    end
  endtask

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_region_table();
    test_directed_modes();
    test_large_offsets();
    test_random_missions();
    drain();
    repeat (10) @(posedge clk);
    $display("sent %0d event words, checked %0d reports, %0d mismatches",
             events_sent, reports_checked, mismatches);
    $display("reached %0d distinct modes, %0d path loads after transfer",
             $countones(modes_seen), path_loads);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
